// ----- rtl/core/pqle_pkg.sv -----
// Shared types and constants for the position query link engine.
`timescale 1ns / 1ps
`default_nettype none

package pqle_pkg;

    localparam int unsigned RESPONSE_LENGTH = 8;
    localparam int unsigned COUNT_W         = $clog2(RESPONSE_LENGTH);

    localparam logic [7:0]  CMD_CODE      = 8'h36;
    localparam logic [7:0]  TRAILER       = 8'h6B;
    localparam logic [15:0] TIMEOUT_RESET = 16'd25;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_BYTE  = 2'd1,
        MODE_TICK  = 2'd2,
        MODE_LINK  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_FRAME = 3'd1,
        ST_RANGE     = 3'd2,
        ST_TIMEOUT   = 3'd3,
        ST_LINK      = 3'd4,
        ST_BUSY      = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'b01,
        PH_WAIT = 2'b10
    } phase_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] dest_addr;
        logic [7:0] rx_byte;
    } req_t;

    typedef struct packed {
        logic               tx_valid;
        logic [7:0]         tx_byte;
        logic               last;
        logic               report_valid;
        status_t            status;
        logic signed [31:0] position;
    } rsp_t;

endpackage

`default_nettype wire

// ----- rtl/core/position_query_link_engine.sv -----
// Top level of the position query link engine: input register, query logic, result buffer.
//
//   channel  | signals                         | direction | content
//   ---------+---------------------------------+-----------+---------------------------------
//   request  | req_valid, req_stall, req_word  | in        | start, received byte, tick, error
//   response | rsp_valid, rsp_stall, rsp_word  | out       | transmit byte or request report
//   config   | cfg_we, cfg_data                | in        | timeout_ticks register
//
// A request word is taken into the input register and is processed in the next cycle
// that the result buffer is free or is handing over its last word. A start from idle
// fills the buffer with a three-word transmit burst; every other request fills it with a
// single report word or leaves it untouched.
// Reset (rst_n, asynchronous) returns the engine to idle and the timeout to 25 ticks.
// A stall on the response side backs up into the input register and then into req_stall.
`timescale 1ns / 1ps
`default_nettype none

module position_query_link_engine (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire pqle_pkg::req_t req_word,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output pqle_pkg::rsp_t      rsp_word,
    input  wire logic           cfg_we,
    input  wire logic [15:0]    cfg_data
);

    // Configuration register.
    logic [15:0] timeout_reg;

    // Input register.
    logic           in_vld_reg, in_vld_next;
    pqle_pkg::req_t in_word_reg;

    // Request state.
    pqle_pkg::phase_t              phase_reg, phase_next;
    logic [7:0]                    target_reg, target_next;
    logic [pqle_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [15:0]                   elapsed_reg, elapsed_next;

    // Received frame bytes; entries are written before they are read in a request.
    logic [7:0] store_reg [pqle_pkg::RESPONSE_LENGTH];
    logic       store_we;

    // Result buffer: either a transmit burst or a single report.
    logic                  buf_vld_reg, buf_vld_next;
    logic                  buf_tx_reg;
    logic [1:0]            buf_idx_reg, buf_idx_next;
    logic [7:0]            buf_addr_reg;
    pqle_pkg::status_t     buf_status_reg;
    logic signed [31:0]    buf_pos_reg;

    logic               advance;
    logic               buf_last;
    logic               pop;
    logic               load;
    logic               load_tx;
    pqle_pkg::status_t  load_status;
    logic signed [31:0] load_pos;

    logic [31:0] mag;
    logic        frame_ok;
    logic [16:0] tick_sum;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign rsp_valid = buf_vld_reg;
    assign buf_last  = !buf_tx_reg || (buf_idx_reg == 2'd2);
    assign pop       = buf_vld_reg && !rsp_stall;
    assign advance   = in_vld_reg && (!buf_vld_reg || (pop && buf_last));
    assign req_stall = in_vld_reg && !advance;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (req_valid && !req_stall)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            in_word_reg <= req_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= pqle_pkg::TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            timeout_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Frame check. The eighth byte is taken straight from the input
    // register, the first seven from the store.
    // ------------------------------------------------------------------
    assign mag = {store_reg[3], store_reg[4], store_reg[5], store_reg[6]};
    assign frame_ok = (store_reg[0] == target_reg) &&
                      (store_reg[1] == pqle_pkg::CMD_CODE) &&
                      (in_word_reg.rx_byte == pqle_pkg::TRAILER);
    assign tick_sum = {1'b0, elapsed_reg} + 17'd1;

    // ------------------------------------------------------------------
    // Request handling
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next   = phase_reg;
        target_next  = target_reg;
        count_next   = count_reg;
        elapsed_next = elapsed_reg;
        store_we     = 1'b0;
        load         = 1'b0;
        load_tx      = 1'b0;
        load_status  = pqle_pkg::ST_OK;
        load_pos     = '0;

        if (advance)
        begin
            case (in_word_reg.mode)
                pqle_pkg::MODE_START:
                begin
                    load = 1'b1;
                    if (phase_reg == pqle_pkg::PH_WAIT)
                    begin
                        load_status = pqle_pkg::ST_BUSY;
                    end
                    else
                    begin
                        load_tx      = 1'b1;
                        phase_next   = pqle_pkg::PH_WAIT;
                        target_next  = in_word_reg.dest_addr;
                        count_next   = '0;
                        elapsed_next = '0;
                    end
                end
                pqle_pkg::MODE_BYTE:
                begin
                    if (phase_reg == pqle_pkg::PH_WAIT)
                    begin
                        store_we = 1'b1;
                        if (count_reg == pqle_pkg::COUNT_W'(pqle_pkg::RESPONSE_LENGTH - 1))
                        begin
                            load       = 1'b1;
                            phase_next = pqle_pkg::PH_IDLE;
                            count_next = '0;
                            if (!frame_ok)
                            begin
                                load_status = pqle_pkg::ST_BAD_FRAME;
                            end
                            else if (mag[31])
                            begin
                                // Magnitude above the largest positive position.
                                load_status = pqle_pkg::ST_RANGE;
                            end
                            else if (store_reg[2] != 8'd0)
                            begin
                                load_pos = -$signed(mag);
                            end
                            else
                            begin
                                load_pos = $signed(mag);
                            end
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
                pqle_pkg::MODE_TICK:
                begin
                    if (phase_reg == pqle_pkg::PH_WAIT)
                    begin
                        if (tick_sum > {1'b0, timeout_reg})
                        begin
                            load        = 1'b1;
                            load_status = pqle_pkg::ST_TIMEOUT;
                            phase_next  = pqle_pkg::PH_IDLE;
                            count_next  = '0;
                        end
                        else
                        begin
                            elapsed_next = tick_sum[15:0];
                        end
                    end
                end
                pqle_pkg::MODE_LINK:
                begin
                    if (phase_reg == pqle_pkg::PH_WAIT)
                    begin
                        load        = 1'b1;
                        load_status = pqle_pkg::ST_LINK;
                        phase_next  = pqle_pkg::PH_IDLE;
                        count_next  = '0;
                    end
                end
                default:
                begin
                    load = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= pqle_pkg::PH_IDLE;
            target_reg  <= '0;
            count_reg   <= '0;
            elapsed_reg <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            target_reg  <= target_next;
            count_reg   <= count_next;
            elapsed_reg <= elapsed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[count_reg] <= in_word_reg.rx_byte;
        end
    end

    // ------------------------------------------------------------------
    // Result buffer. A new result is loaded only when the buffer is empty
    // or its last word leaves in the same cycle.
    // ------------------------------------------------------------------
    always_comb
    begin
        buf_vld_next = buf_vld_reg;
        buf_idx_next = buf_idx_reg;
        if (load)
        begin
            buf_vld_next = 1'b1;
            buf_idx_next = '0;
        end
        else if (pop)
        begin
            if (buf_last)
            begin
                buf_vld_next = 1'b0;
            end
            else
            begin
                buf_idx_next = buf_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_vld_reg <= 1'b0;
            buf_idx_reg <= '0;
        end
        else
        begin
            buf_vld_reg <= buf_vld_next;
            buf_idx_reg <= buf_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            buf_tx_reg     <= load_tx;
            buf_addr_reg   <= in_word_reg.dest_addr;
            buf_status_reg <= load_status;
            buf_pos_reg    <= load_pos;
        end
    end

    // Output word, decoded from the buffer registers.
    always_comb
    begin
        rsp_word.tx_valid     = buf_tx_reg;
        rsp_word.last         = buf_last;
        rsp_word.report_valid = !buf_tx_reg;
        rsp_word.status       = buf_tx_reg ? pqle_pkg::ST_OK : buf_status_reg;
        rsp_word.position     = buf_tx_reg ? 32'sd0 : buf_pos_reg;
        rsp_word.tx_byte      = 8'd0;
        if (buf_tx_reg)
        begin
            case (buf_idx_reg)
                2'd0:    rsp_word.tx_byte = buf_addr_reg;
                2'd1:    rsp_word.tx_byte = pqle_pkg::CMD_CODE;
                default: rsp_word.tx_byte = pqle_pkg::TRAILER;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/pqle_checker.sv -----
// Port-level checker for the position query link engine and its bind.
`timescale 1ns / 1ps
`default_nettype none

module pqle_checker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    input  wire logic           req_stall,
    input  wire pqle_pkg::req_t req_word,
    input  wire logic           rsp_valid,
    input  wire logic           rsp_stall,
    input  wire pqle_pkg::rsp_t rsp_word,
    input  wire logic           cfg_we,
    input  wire logic [15:0]    cfg_data
);

    // A stalled response word stays offered.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("response word withdrawn while stalled");

    // A stalled response word does not change.
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(rsp_word))
        else $error("response word changed while stalled");

    // Every word is either a transmit byte or a report, never both.
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_word.tx_valid ^ rsp_word.report_valid))
        else $error("response word kind is ambiguous");

    // A report always closes the results of its request.
    a_report_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.report_valid |-> rsp_word.last)
        else $error("report word without last");

    // A failed request carries no position.
    a_fail_pos: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.report_valid && (rsp_word.status != pqle_pkg::ST_OK)
        |-> (rsp_word.position == 32'sd0))
        else $error("position set in a failure report");

endmodule

bind position_query_link_engine pqle_checker u_pqle_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
);

`default_nettype wire
